/* hdl/tcch_pkg.sv */
package tcch_pkg;

  // angle word: degrees in Q16
  localparam int AngW = 27;
  localparam int AtanEntries = 24;
  localparam int StepW = 5;
  localparam int GainW = 16;
  localparam int KW = 25;
  localparam int OpBW = 26;
  localparam int FieldW = 32;
  localparam int HeadW = 9;
  localparam int AccW = 44;
  localparam logic [GainW-1:0] GainReset = 16'd15729;
  localparam logic signed [AngW-1:0] HalfTurn = 27'sd11796480;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAG_MUL,
    ST_MAG_WB,
    ST_ROLL_LOAD,
    ST_ROLL_RUN,
    ST_PITCH_MUL_G,
    ST_PITCH_MUL_F,
    ST_PITCH_LOAD,
    ST_PITCH_RUN,
    ST_YAW_MUL,
    ST_YAW_LOAD,
    ST_YAW_RUN,
    ST_HEAD_MUL_P,
    ST_HEAD_MUL_Q,
    ST_HEAD_SUM,
    ST_HEAD_OUT
  } state_t;

  typedef enum logic {
    FUNC_MAG = 1'b0,
    FUNC_ACCEL = 1'b1
  } func_t;

  // arctangent of 2^-i in degrees Q16, rounded
  function automatic logic signed [AngW-1:0] atan_q16(input logic [StepW-1:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      5'd0: v = 27'sd2949120;
      5'd1: v = 27'sd1740967;
      5'd2: v = 27'sd919879;
      5'd3: v = 27'sd466945;
      5'd4: v = 27'sd234379;
      5'd5: v = 27'sd117304;
      5'd6: v = 27'sd58666;
      5'd7: v = 27'sd29335;
      5'd8: v = 27'sd14668;
      5'd9: v = 27'sd7334;
      5'd10: v = 27'sd3667;
      5'd11: v = 27'sd1833;
      5'd12: v = 27'sd917;
      5'd13: v = 27'sd458;
      5'd14: v = 27'sd229;
      5'd15: v = 27'sd115;
      5'd16: v = 27'sd57;
      5'd17: v = 27'sd29;
      5'd18: v = 27'sd14;
      5'd19: v = 27'sd7;
      5'd20: v = 27'sd4;
      5'd21: v = 27'sd2;
      5'd22: v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

  // cordic gain in Q24, evaluated at elaboration
  function automatic logic [KW-1:0] cordic_gain_q24(input int steps);
    logic [63:0] p;
    logic [63:0] term;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] bv;
    p = 64'd1 << 30;
    for (int i = 0; i < AtanEntries; i++) begin
      if (i < steps) begin
        term = (2 * i <= 30) ? ((64'd1 << 30) >> (2 * i)) : 64'd0;
        p = (p * ((64'd1 << 30) + term)) >> 30;
      end
    end
    n = p << 18;
    r = 64'd0;
    bv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bv > n) bv = bv >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bv != 64'd0) begin
        if (n >= r + bv) begin
          n = n - (r + bv);
          r = (r >> 1) + bv;
        end else begin
          r = r >> 1;
        end
        bv = bv >> 2;
      end
    end
    return r[KW-1:0];
  endfunction

endpackage

/* hdl/tcch_if.sv */
interface tcch_in_if #(parameter int SAMPLE_BITS = 16);
  logic valid;
  logic ready;
  logic func;
  logic signed [SAMPLE_BITS-1:0] axis_x;
  logic signed [SAMPLE_BITS-1:0] axis_y;
  logic signed [SAMPLE_BITS-1:0] axis_z;
  logic [1:0] calib_level;
  logic [31:0] stamp;
  modport source (output valid, func, axis_x, axis_y, axis_z, calib_level, stamp,
                  input ready);
  modport sink (input valid, func, axis_x, axis_y, axis_z, calib_level, stamp,
                output ready);
endinterface

interface tcch_out_if;
  logic valid;
  logic ready;
  logic [8:0] heading_degrees;
  logic [1:0] heading_level;
  logic [31:0] heading_stamp;
  modport source (output valid, heading_degrees, heading_level, heading_stamp,
                  input ready);
  modport sink (input valid, heading_degrees, heading_level, heading_stamp,
                output ready);
endinterface

interface tcch_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* hdl/tcch_mul.sv */
module tcch_mul #(
  parameter int AW = 28,
  parameter int BW = 26
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] prod
);

  // registered product
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

/* hdl/tcch_cordic.sv */
module tcch_cordic #(
  parameter int DW = 42,
  parameter int STEPS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  logic signed [DW-1:0]                   lx,
  input  logic signed [DW-1:0]                   ly,
  input  logic signed [DW-1:0]                   lu,
  input  logic signed [DW-1:0]                   lv,
  output logic signed [DW-1:0]                   x,
  output logic signed [DW-1:0]                   u,
  output logic signed [DW-1:0]                   v,
  output logic signed [tcch_pkg::AngW-1:0]       ang,
  output logic                                   busy
);

  logic signed [DW-1:0] y;
  logic [tcch_pkg::StepW-1:0] cnt;
  logic signed [DW-1:0] dx, dy, du, dv;
  logic signed [tcch_pkg::AngW-1:0] da;

  // shifted terms of one micro-rotation
  always_comb begin
    dx = y >>> cnt;
    dy = x >>> cnt;
    du = v >>> cnt;
    dv = u >>> cnt;
    da = tcch_pkg::atan_q16(cnt);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == tcch_pkg::StepW'(STEPS - 1)) busy <= 1'b0;
    end
  end

  // vector registers: half turn on load if x is negative, then micro-rotations
  always_ff @(posedge clk) begin
    if (load) begin
      if (lx[DW-1]) begin
        x   <= -lx;
        y   <= -ly;
        u   <= -lu;
        v   <= -lv;
        ang <= ly[DW-1] ? -tcch_pkg::HalfTurn : tcch_pkg::HalfTurn;
      end else begin
        x   <= lx;
        y   <= ly;
        u   <= lu;
        v   <= lv;
        ang <= '0;
      end
    end else if (busy) begin
      if (!y[DW-1]) begin
        x   <= x + dx;
        y   <= y - dy;
        u   <= u + du;
        v   <= v - dv;
        ang <= ang + da;
      end else begin
        x   <= x - dx;
        y   <= y + dy;
        u   <= u - du;
        v   <= v + dv;
        ang <= ang - da;
      end
    end
  end

endmodule

/* hdl/tilt_compensated_compass_heading.sv */
// magnetometer transaction: field filter per axis through the shared multiplier
// accelerometer transaction: result registered after three vectoring passes of
// the one cordic unit (roll, pitch, yaw) and the heading filter multiplies
// one transaction in flight; ready again the cycle after it leaves the datapath,
// later while a result waits on the output
// synchronous reset: gain 15729, filtered field, level and previous heading zero
module tilt_compensated_compass_heading #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  tcch_in_if.sink  samples,
  tcch_out_if.source result,
  tcch_cfg_if.sink cfg
);

  localparam int DW = SAMPLE_BITS + 26;
  localparam int MW = (SAMPLE_BITS + 12 > 32) ? SAMPLE_BITS + 12 : 32;
  localparam int PW = MW + tcch_pkg::OpBW;
  localparam logic [tcch_pkg::KW-1:0] KGain = tcch_pkg::cordic_gain_q24(CORDIC_STEPS);

  tcch_pkg::state_t state, state_next;

  logic [tcch_pkg::GainW-1:0] gain;
  logic signed [tcch_pkg::FieldW-1:0] field [3];
  logic [1:0] level;
  logic signed [tcch_pkg::HeadW-1:0] prev;
  logic signed [SAMPLE_BITS-1:0] smp [3];
  logic [31:0] stamp;
  logic [1:0] j;
  logic signed [DW-1:0] neg_d;
  logic signed [DW-1:0] my_save;
  logic signed [tcch_pkg::AccW-1:0] acc_p;
  logic signed [tcch_pkg::AccW-1:0] acc;

  logic signed [MW-1:0] mul_a;
  logic signed [tcch_pkg::OpBW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] scaled;

  logic cload;
  logic signed [DW-1:0] lx, ly, lu, lv;
  logic signed [DW-1:0] cx, cu, cv;
  logic signed [tcch_pkg::AngW-1:0] cang;
  logic cbusy;

  logic in_acc;
  logic out_free;
  logic signed [DW-1:0] s_ext, f_ext, diff;
  logic signed [11:0] h_floor, h_trunc;
  logic signed [tcch_pkg::HeadW-1:0] h_clamp;
  logic [9:0] h_pos;
  logic [8:0] deg;

  assign samples.ready = (state == tcch_pkg::ST_IDLE);
  assign cfg.ready = 1'b1;
  assign in_acc = samples.valid && samples.ready;
  assign out_free = !result.valid || result.ready;

  // shared units
  tcch_mul #(.AW(MW), .BW(tcch_pkg::OpBW)) u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .prod(prod)
  );

  tcch_cordic #(.DW(DW), .STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .load(cload), .lx(lx), .ly(ly), .lu(lu), .lv(lv),
    .x(cx), .u(cu), .v(cv), .ang(cang), .busy(cbusy)
  );

  // product scaled by 2^-24, back to datapath width
  assign scaled = {{(DW-MW){prod[MW+23]}}, prod[MW+23:24]};

  // field filter difference for component j
  always_comb begin
    s_ext = {{(DW-SAMPLE_BITS){smp[j][SAMPLE_BITS-1]}}, smp[j]};
    f_ext = {{(DW-tcch_pkg::FieldW){field[j][tcch_pkg::FieldW-1]}}, field[j]};
    diff  = {s_ext[DW-9:0], 8'd0} - f_ext;
  end

  // heading: truncate toward zero, clamp, wrap to 0..359
  always_comb begin
    h_floor = acc[tcch_pkg::AccW-1:32];
    h_trunc = (acc[tcch_pkg::AccW-1] && (acc[31:0] != 32'd0)) ? h_floor + 12'sd1 : h_floor;
    if (h_trunc > 12'sd255) h_clamp = 9'sd255;
    else if (h_trunc < -12'sd256) h_clamp = -9'sd256;
    else h_clamp = h_trunc[8:0];
    h_pos = 10'({h_clamp[8], h_clamp} + 10'sd360);
    deg = (h_pos >= 10'd360) ? 9'(h_pos - 10'd360) : h_pos[8:0];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= tcch_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state, multiplier operands and cordic load
  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = {{(tcch_pkg::OpBW-tcch_pkg::KW){1'b0}}, KGain};
    cload = 1'b0;
    lx = cx;
    ly = neg_d;
    lu = cu;
    lv = cv;
    case (state)
      tcch_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = (samples.func == tcch_pkg::FUNC_MAG) ?
                       tcch_pkg::ST_MAG_MUL : tcch_pkg::ST_ROLL_LOAD;
        end
      end
      tcch_pkg::ST_MAG_MUL: begin
        mul_a = diff[MW-1:0];
        mul_b = {{(tcch_pkg::OpBW-tcch_pkg::GainW){1'b0}}, gain};
        state_next = tcch_pkg::ST_MAG_WB;
      end
      tcch_pkg::ST_MAG_WB: begin
        state_next = (j == 2'd2) ? tcch_pkg::ST_IDLE : tcch_pkg::ST_MAG_MUL;
      end
      tcch_pkg::ST_ROLL_LOAD: begin
        cload = 1'b1;
        lx = -{{(DW-SAMPLE_BITS-8){smp[2][SAMPLE_BITS-1]}}, smp[2], 8'd0};
        ly = {{(DW-SAMPLE_BITS-8){smp[1][SAMPLE_BITS-1]}}, smp[1], 8'd0};
        lu = {{(DW-tcch_pkg::FieldW){field[2][tcch_pkg::FieldW-1]}}, field[2]};
        lv = {{(DW-tcch_pkg::FieldW){field[1][tcch_pkg::FieldW-1]}}, field[1]};
        state_next = tcch_pkg::ST_ROLL_RUN;
      end
      tcch_pkg::ST_ROLL_RUN: begin
        if (!cbusy) state_next = tcch_pkg::ST_PITCH_MUL_G;
      end
      tcch_pkg::ST_PITCH_MUL_G: begin
        mul_a = {{(MW-SAMPLE_BITS-8){smp[0][SAMPLE_BITS-1]}}, smp[0], 8'd0};
        state_next = tcch_pkg::ST_PITCH_MUL_F;
      end
      tcch_pkg::ST_PITCH_MUL_F: begin
        mul_a = MW'(field[0]);
        state_next = tcch_pkg::ST_PITCH_LOAD;
      end
      tcch_pkg::ST_PITCH_LOAD: begin
        cload = 1'b1;
        lx = cx;
        ly = neg_d;
        lu = scaled;
        lv = cu;
        state_next = tcch_pkg::ST_PITCH_RUN;
      end
      tcch_pkg::ST_PITCH_RUN: begin
        if (!cbusy) state_next = tcch_pkg::ST_YAW_MUL;
      end
      tcch_pkg::ST_YAW_MUL: begin
        mul_a = my_save[MW-1:0];
        state_next = tcch_pkg::ST_YAW_LOAD;
      end
      tcch_pkg::ST_YAW_LOAD: begin
        cload = 1'b1;
        lx = cu;
        ly = -scaled;
        lu = '0;
        lv = '0;
        state_next = tcch_pkg::ST_YAW_RUN;
      end
      tcch_pkg::ST_YAW_RUN: begin
        if (!cbusy) state_next = tcch_pkg::ST_HEAD_MUL_P;
      end
      tcch_pkg::ST_HEAD_MUL_P: begin
        mul_a = {{(MW-tcch_pkg::AngW){cang[tcch_pkg::AngW-1]}}, cang};
        mul_b = {{(tcch_pkg::OpBW-tcch_pkg::GainW){1'b0}}, gain};
        state_next = tcch_pkg::ST_HEAD_MUL_Q;
      end
      tcch_pkg::ST_HEAD_MUL_Q: begin
        mul_a = {{(MW-tcch_pkg::HeadW){prev[tcch_pkg::HeadW-1]}}, prev};
        mul_b = {{(tcch_pkg::OpBW-17){1'b0}}, 17'(17'd65536 - {1'b0, gain})};
        state_next = tcch_pkg::ST_HEAD_SUM;
      end
      tcch_pkg::ST_HEAD_SUM: begin
        state_next = tcch_pkg::ST_HEAD_OUT;
      end
      tcch_pkg::ST_HEAD_OUT: begin
        if (out_free) state_next = tcch_pkg::ST_IDLE;
      end
      default: state_next = tcch_pkg::ST_IDLE;
    endcase
  end

  // gain register
  always_ff @(posedge clk) begin
    if (rst) gain <= tcch_pkg::GainReset;
    else if (cfg.valid && cfg.ready) gain <= cfg.data;
  end

  // stored field, level and previous heading
  always_ff @(posedge clk) begin
    if (rst) begin
      field[0] <= '0;
      field[1] <= '0;
      field[2] <= '0;
      level    <= '0;
      prev     <= '0;
    end else begin
      if (in_acc && samples.func == tcch_pkg::FUNC_MAG) level <= samples.calib_level;
      if (state == tcch_pkg::ST_MAG_WB) field[j] <= field[j] + prod[tcch_pkg::FieldW+15:16];
      if (state == tcch_pkg::ST_HEAD_OUT && out_free) prev <= h_clamp;
    end
  end

  // latched transaction and working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp[0] <= samples.axis_y;
      smp[1] <= samples.axis_x;
      smp[2] <= samples.axis_z;
      stamp  <= samples.stamp;
      j      <= '0;
    end
    if (state == tcch_pkg::ST_MAG_WB) j <= j + 1'b1;
    if (state == tcch_pkg::ST_PITCH_MUL_F) begin
      neg_d   <= -scaled;
      my_save <= cv;
    end
    if (state == tcch_pkg::ST_HEAD_MUL_Q) acc_p <= prod[tcch_pkg::AccW-1:0];
    if (state == tcch_pkg::ST_HEAD_SUM) begin
      acc <= acc_p + {prod[tcch_pkg::AccW-17:0], 16'd0};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == tcch_pkg::ST_HEAD_OUT && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tcch_pkg::ST_HEAD_OUT && out_free) begin
      result.heading_degrees <= deg;
      result.heading_level   <= level;
      result.heading_stamp   <= stamp;
    end
  end

  // checks
  a_idle_cordic: assert property (@(posedge clk) disable iff (rst)
    (state == tcch_pkg::ST_IDLE) |-> !cbusy)
    else $error("cordic busy while idle");

  a_deg_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.heading_degrees < 9'd360))
    else $error("heading out of range");

  a_mag_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_acc && samples.func == tcch_pkg::FUNC_MAG) |=> !$rose(result.valid))
    else $error("result after magnetometer transaction");

endmodule

/* dv/tb_tilt_compensated_compass_heading.sv */
module tb_tilt_compensated_compass_heading;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Steps = 16;
  localparam int DrainCycles = 80;
  localparam int WatchdogLimit = 3000;

  typedef struct {
    logic [8:0] degrees;
    logic [1:0] level;
    logic [31:0] stamp;
  } heading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcch_in_if #(.SAMPLE_BITS(16)) in_if ();
  tcch_out_if out_if ();
  tcch_cfg_if cfg_if ();

  tilt_compensated_compass_heading #(
    .CORDIC_STEPS(Steps),
    .SAMPLE_BITS(16)
  ) uut (
    .clk(clk),
    .rst(rst),
    .samples(in_if),
    .result(out_if),
    .cfg(cfg_if)
  );

  // model of the block state
  longint unsigned gain_now;
  int field_now[3];
  logic [1:0] level_now;
  longint prev_heading;

  heading_t heading_expected[$];
  int errors = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // arithmetic shift right with floor
  function automatic longint shr_floor(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // cordic scale factor in Q24
  function automatic longint cordic_k_q24();
    longint unsigned p;
    longint unsigned term;
    p = 64'd1 << 30;
    for (int i = 0; i < Steps; i++) begin
      term = (2 * i <= 30) ? ((64'd1 << 30) >> (2 * i)) : 64'd0;
      p = (p * ((64'd1 << 30) + term)) >> 30;
    end
    return longint'(int_sqrt(p << 18));
  endfunction

  function automatic longint atan_entry(input int i);
    int tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                    14668, 7334, 3667, 1833, 917, 458, 229, 115,
                    57, 29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  // rotate (x, y) onto the positive x axis, (u, v) alongside; returns angle
  function automatic longint rotate_to_axis(inout longint x, inout longint y,
                                            inout longint u, inout longint v);
    longint ang;
    longint dx, dy, du, dv;
    ang = 0;
    if (x < 0) begin
      ang = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x; y = -y; u = -u; v = -v;
    end
    for (int i = 0; i < Steps; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      du = shr_floor(v, i);
      dv = shr_floor(u, i);
      if (y >= 0) begin
        x += dx; y -= dy; u += du; v -= dv;
        ang += atan_entry(i);
      end else begin
        x -= dx; y += dy; u -= du; v += dv;
        ang -= atan_entry(i);
      end
    end
    return ang;
  endfunction

  // update the model for one sample; returns 1 with the heading on accel samples
  function automatic bit predict_heading(input tcch_pkg::func_t f,
                                         input logic signed [15:0] ax,
                                         input logic signed [15:0] ay,
                                         input logic signed [15:0] az,
                                         input logic [1:0] lvl, input logic [31:0] stp,
                                         output heading_t res);
    longint s[3];
    longint g, k, a, b, mz, my, c, d, p, q, x, y, du, dv, psi, acc, h, deg, old;
    g = longint'(gain_now);
    res = '{default: '0};
    if (f == tcch_pkg::FUNC_MAG) begin
      s[0] = ay; s[1] = ax; s[2] = az;
      for (int j = 0; j < 3; j++) begin
        old = field_now[j];
        field_now[j] = int'(old + shr_floor((s[j] * 256 - old) * g, 16));
      end
      level_now = lvl;
      return 1'b0;
    end
    k = cordic_k_q24();
    a = -longint'(az) * 256;
    b = longint'(ax) * 256;
    mz = field_now[2];
    my = field_now[1];
    void'(rotate_to_axis(a, b, mz, my));
    // pitch
    c = a;
    d = -shr_floor(longint'(ay) * 256 * k, 24);
    p = shr_floor(longint'(field_now[0]) * k, 24);
    q = mz;
    void'(rotate_to_axis(c, d, p, q));
    // yaw
    x = p;
    y = -shr_floor(my * k, 24);
    du = 0;
    dv = 0;
    psi = rotate_to_axis(x, y, du, dv);
    acc = psi * g + prev_heading * (65536 - g) * 65536;
    h = acc / 64'sd4294967296;
    if (h > 255) h = 255;
    if (h < -256) h = -256;
    prev_heading = h;
    deg = (h + 360) % 360;
    if (deg < 0) deg += 360;
    res.degrees = deg[8:0];
    res.level = level_now;
    res.stamp = stp;
    return 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    heading_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (heading_expected.size() == 0) begin
        $error("unexpected result transaction: degrees %0d", out_if.heading_degrees);
        errors++;
      end else begin
        want = heading_expected.pop_front();
        if (out_if.heading_degrees !== want.degrees) begin
          $error("heading_degrees: expected %0d, got %0d", want.degrees,
                 out_if.heading_degrees);
          errors++;
        end
        if (out_if.heading_level !== want.level) begin
          $error("heading_level: expected %0d, got %0d", want.level, out_if.heading_level);
          errors++;
        end
        if (out_if.heading_stamp !== want.stamp) begin
          $error("heading_stamp: expected %0h, got %0h", want.stamp, out_if.heading_stamp);
          errors++;
        end
      end
    end
  end

  // result back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[tilt_compensated_compass_heading] ERROR");
        $finish;
      end
    end
  end

  task automatic send_sample(input tcch_pkg::func_t f, input logic signed [15:0] ax,
                             input logic signed [15:0] ay, input logic signed [15:0] az,
                             input logic [1:0] lvl, input logic [31:0] stp);
    heading_t res;
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.func = f;
    in_if.axis_x = ax;
    in_if.axis_y = ay;
    in_if.axis_z = az;
    in_if.calib_level = lvl;
    in_if.stamp = stp;
    do @(posedge clk); while (!in_if.ready);
    if (predict_heading(f, ax, ay, az, lvl, stp, res)) heading_expected.push_back(res);
  endtask

  // drop valid, then let the block run dry
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (heading_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_gain(input logic [15:0] g);
    drain();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data = g;
    do @(posedge clk); while (!cfg_if.ready);
    gain_now = g;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 4000)) - 2000);
      default: return 16'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  task automatic send_random(input int n);
    tcch_pkg::func_t f;
    for (int i = 0; i < n; i++) begin
      f = ($urandom_range(0, 2) == 0) ? tcch_pkg::FUNC_MAG : tcch_pkg::FUNC_ACCEL;
      send_sample(f, rand_axis(), rand_axis(), rand_axis(), 2'($urandom), $urandom);
    end
  endtask

  // extremes, both kinds, negative-x and zero-gravity cases
  task automatic test_directed();
    send_sample(tcch_pkg::FUNC_ACCEL, 16'sd0, 16'sd0, 16'sd0, 2'd3, 32'h0000_0000);
    send_sample(tcch_pkg::FUNC_MAG, 16'sd32767, -16'sd32768, 16'sd32767, 2'd1,
                32'hffff_ffff);
    send_sample(tcch_pkg::FUNC_MAG, 16'sd20000, -16'sd5000, 16'sd100, 2'd2, 32'h1234_5678);
    send_sample(tcch_pkg::FUNC_ACCEL, 16'sd0, 16'sd0, -16'sd1000, 2'd0, 32'hffff_ffff);
    send_sample(tcch_pkg::FUNC_ACCEL, 16'sd0, 16'sd0, 16'sd1000, 2'd0, 32'h8000_0001);
    send_sample(tcch_pkg::FUNC_ACCEL, 16'sd32767, -16'sd32768, 16'sd32767, 2'd0,
                32'h5555_aaaa);
    send_sample(tcch_pkg::FUNC_ACCEL, -16'sd32768, 16'sd32767, -16'sd32768, 2'd0,
                32'haaaa_5555);
    send_sample(tcch_pkg::FUNC_MAG, -16'sd32768, 16'sd32767, -16'sd32768, 2'd0, 32'h0);
    send_sample(tcch_pkg::FUNC_MAG, 16'sd0, 16'sd0, 16'sd0, 2'd3, 32'h0);
    send_sample(tcch_pkg::FUNC_ACCEL, 16'sd500, -16'sd300, -16'sd9800, 2'd1, 32'h0000_0001);
    send_sample(tcch_pkg::FUNC_ACCEL, -16'sd500, 16'sd300, 16'sd9800, 2'd1, 32'h7fff_ffff);
    send_sample(tcch_pkg::FUNC_MAG, -16'sd30000, -16'sd30000, 16'sd0, 2'd2, 32'h0);
    for (int i = 0; i < 6; i++)
      send_sample(tcch_pkg::FUNC_ACCEL, 16'sd0, 16'sd0, -16'sd9800, 2'd0, 32'(i));
  endtask

  // gain at both extremes and in between
  task automatic test_gain_settings();
    write_gain(16'd0);
    send_random(40);
    write_gain(16'd65535);
    send_random(60);
    write_gain(16'd1);
    send_random(30);
    write_gain(16'($urandom));
    send_random(60);
  endtask

  task automatic test_random();
    write_gain(tcch_pkg::GainReset);
    send_random(500);
    write_gain(16'd40000);
    send_random(150);
    // last part without idling
    idle_on = 1'b0;
    send_random(100);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.func = tcch_pkg::FUNC_MAG;
    in_if.axis_x = '0;
    in_if.axis_y = '0;
    in_if.axis_z = '0;
    in_if.calib_level = '0;
    in_if.stamp = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b1;
    gain_now = tcch_pkg::GainReset;
    field_now = '{0, 0, 0};
    level_now = '0;
    prev_heading = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_gain_settings();
    test_random();
    drain();

    if (errors == 0) begin
      $display("[tilt_compensated_compass_heading] OK");
    end else begin
      $display("[tilt_compensated_compass_heading] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/tcch_pkg.sv
hdl/tcch_if.sv
hdl/tcch_mul.sv
hdl/tcch_cordic.sv
hdl/tilt_compensated_compass_heading.sv
dv/tb_tilt_compensated_compass_heading.sv
